// File: rtl/cdad_pkg.sv
// Shared types and constants for the calendar date add/subtract-days block.
package cdad_pkg;

  // Fixed field widths
  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int SyearW = 14;
  localparam int OyearW = 16;
  localparam int CountW = 16;
  // Working year: wide enough for any date reachable within one day count
  localparam int YearW  = (CountW > 19) ? CountW - 4 : OyearW;

  // Direction codes
  localparam logic DirAdd = 1'b0;
  localparam logic DirSub = 1'b1;

  // Month numbers
  localparam logic [MonthW-1:0] MonJan  = 4'd1;
  localparam logic [MonthW-1:0] MonFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonMar  = 4'd3;
  localparam logic [MonthW-1:0] MonApr  = 4'd4;
  localparam logic [MonthW-1:0] MonMay  = 4'd5;
  localparam logic [MonthW-1:0] MonJun  = 4'd6;
  localparam logic [MonthW-1:0] MonJul  = 4'd7;
  localparam logic [MonthW-1:0] MonAug  = 4'd8;
  localparam logic [MonthW-1:0] MonSep  = 4'd9;
  localparam logic [MonthW-1:0] MonOct  = 4'd10;
  localparam logic [MonthW-1:0] MonNov  = 4'd11;
  localparam logic [MonthW-1:0] MonDec  = 4'd12;
  localparam logic [MonthW-1:0] MonWrap = 4'd13;

  // Day thresholds (6-bit to hold the forward sum)
  localparam logic [DayW:0] DayPast31 = 6'd32;
  localparam logic [DayW:0] DayPast30 = 6'd31;
  localparam logic [DayW:0] DayPast29 = 6'd30;
  localparam logic [DayW:0] DayPast28 = 6'd29;
  localparam logic [DayW-1:0] Day31   = 5'd31;
  localparam logic [DayW-1:0] Day30   = 5'd30;
  localparam logic [DayW-1:0] Day29   = 5'd29;
  localparam logic [DayW-1:0] Day28   = 5'd28;
  localparam logic [DayW-1:0] DayOne  = 5'd1;

  typedef struct packed {
    logic              req_type;
    logic [DayW-1:0]   start_day;
    logic [MonthW-1:0] start_month;
    logic [SyearW-1:0] start_year;
    logic [CountW-1:0] day_count;
  } in_t;

  typedef struct packed {
    logic               [DayW-1:0]   out_day;
    logic               [MonthW-1:0] out_month;
    logic signed        [OyearW-1:0] out_year;
    logic                            input_error;
    logic                            before_era;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// File: rtl/calendar_date_add_subtract_days_top.sv
// Top level of the calendar date add/subtract-days block.
//
//   channel  | direction | handshake                  | word
//   ---------+-----------+----------------------------+-----------------
//   request  | in        | in_valid_i / in_ready_o    | in_word_i  (in_t)
//   result   | out       | out_valid_o / out_ready_i  | out_word_o (out_t)
//
// Each word is loaded, then stepped one day per count through the shared step
// unit, then the date is moved into the result register.
// A zero day or month ends stepping early with input_error set.
// rst_ni clears the controller and the result valid; the date registers need no reset.
// A pending result does not block the next request; only the final hand-off
// waits while the result register still holds an untaken word.
module calendar_date_add_subtract_days_top import cdad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_word_o
);

  cmd_t cmd;
  sts_t sts;

  cdad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cdad_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_word_i (in_word_i),
    .sts_o     (sts),
    .out_word_o(out_word_o)
  );

endmodule

// File: rtl/cdad_datapath.sv
// Date stepping datapath: working date, count, flags and result register.
module cdad_datapath import cdad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_word_i,
  output sts_t sts_o,
  output out_t out_word_o
);

  logic                     dir_q;
  logic [DayW-1:0]          day_q, day_d;
  logic [MonthW-1:0]        mon_q, mon_d;
  logic signed [YearW-1:0]  year_q, year_d;
  logic [CountW-1:0]        count_q;
  logic                     era_q, era_d;
  out_t                     out_q;

  logic                     leap;
  logic [DayW:0]            sum;
  logic                     wrap_fwd;
  logic                     has31, has30;
  logic [DayW-1:0]          dec;

  assign leap  = (year_q[1:0] == 2'b00);
  assign has31 = (mon_q == MonJan) || (mon_q == MonMar) || (mon_q == MonMay) ||
                 (mon_q == MonJul) || (mon_q == MonAug) || (mon_q == MonOct) ||
                 (mon_q == MonDec);
  assign has30 = (mon_q == MonApr) || (mon_q == MonJun) || (mon_q == MonSep) ||
                 (mon_q == MonNov);
  assign sum   = {1'b0, day_q} + {{DayW{1'b0}}, 1'b1};
  assign dec   = day_q - DayOne;
  assign wrap_fwd = ((sum == DayPast31) && has31) || ((sum == DayPast30) && has30) ||
                    ((sum == DayPast29) && (mon_q == MonFeb) && leap) ||
                    ((sum == DayPast28) && (mon_q == MonFeb) && !leap);

  // One calendar day forward or backward
  always_comb begin
    day_d  = day_q;
    mon_d  = mon_q;
    year_d = year_q;
    era_d  = era_q;
    if (dir_q == DirAdd) begin
      if (wrap_fwd) begin
        day_d = DayOne;
        mon_d = mon_q + 4'd1;
      end else begin
        day_d = sum[DayW-1:0];
      end
      if (mon_d == MonWrap) begin
        mon_d  = MonJan;
        year_d = year_q + YearW'(1);
      end
    end else begin
      day_d = dec;
      if (dec == '0) begin
        case (mon_q)
          MonMay, MonJul, MonOct, MonDec: begin
            day_d = Day30;
            mon_d = mon_q - 4'd1;
          end
          MonApr, MonJun, MonAug, MonSep, MonNov, MonJan, MonFeb: begin
            day_d = Day31;
            mon_d = mon_q - 4'd1;
          end
          MonMar: begin
            day_d = leap ? Day29 : Day28;
            mon_d = mon_q - 4'd1;
          end
          default: begin
            mon_d = mon_q;
          end
        endcase
      end
      if (mon_d == '0) begin
        mon_d  = MonDec;
        year_d = year_q - YearW'(1);
      end
      if (year_d < 0) begin
        era_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= in_word_i.day_count;
    end else if (cmd_i.step) begin
      count_q <= count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dir_q  <= in_word_i.req_type;
      day_q  <= in_word_i.start_day;
      mon_q  <= in_word_i.start_month;
      year_q <= YearW'(in_word_i.start_year);
      era_q  <= 1'b0;
    end else if (cmd_i.step) begin
      day_q  <= day_d;
      mon_q  <= mon_d;
      year_q <= year_d;
      era_q  <= era_d;
    end
  end

  // Stepping ends on zero count, or early on a zero day or month
  assign sts_o.done = (count_q == '0) || (day_q == '0) || (mon_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.out_day     <= day_q;
      out_q.out_month   <= mon_q;
      out_q.out_year    <= year_q[OyearW-1:0];
      out_q.input_error <= (count_q != '0);
      out_q.before_era  <= era_q;
    end
  end

  assign out_word_o = out_q;

endmodule

// File: rtl/cdad_ctrl.sv
// Controller: accepts a word, sequences the day steps, hands off the result.
module cdad_ctrl import cdad_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
        end
      end
      StRun: begin
        if (!sts_i.done) begin
          cmd_o.step = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          // Hold until the result register frees up
          cmd_o.publish = 1'b1;
          state_d       = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/calendar_date_add_subtract_days_chk.sv
// Port-level checker for the calendar date block, bound to the top level.
module cdad_chk import cdad_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_word_o
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word dropped or changed while stalled");

  // Only one request in flight
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while stepping");

  // An input error leaves a zero day or month behind
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.input_error |->
      (out_word_o.out_day == '0) || (out_word_o.out_month == '0))
    else $error("input_error without zero day or month");

  // Era flag matches a negative year
  a_era_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.before_era == out_word_o.out_year[OyearW-1]))
    else $error("before_era disagrees with year sign");

endmodule

bind calendar_date_add_subtract_days_top cdad_chk u_cdad_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_word_o (out_word_o)
);

// File: dv/tb_top.sv
// Self-checking testbench for the calendar date add/subtract-days block.
`timescale 1ns / 1ps

module tb_top;
  import cdad_pkg::*;

  typedef struct packed {
    logic typed;
    in_t  word;
    out_t want;
  } row_t;

  localparam int NumRows    = 23;
  localparam int NumRandom  = 80;
  localparam int MaxCycles  = 4_000_000;
  localparam int TailCycles = 20;

  // Rows with typed = 1 carry their expected date; the rest go through the predictor.
  localparam row_t DirRows [NumRows] = '{
    '{1'b1, '{DirAdd, 5'd1, MonJan, 14'd2000, 16'd0}, '{5'd1, MonJan, 16'd2000, 1'b0, 1'b0}},
    '{1'b1, '{DirSub, 5'd0, 4'd0, 14'd16383, 16'd0}, '{5'd0, 4'd0, 16'd16383, 1'b0, 1'b0}},
    '{1'b1, '{DirAdd, 5'd0, MonMay, 14'd100, 16'd3}, '{5'd0, MonMay, 16'd100, 1'b1, 1'b0}},
    '{1'b1, '{DirSub, 5'd3, 4'd0, 14'd7, 16'hFFFF}, '{5'd3, 4'd0, 16'd7, 1'b1, 1'b0}},
    '{1'b1, '{DirSub, 5'd0, 4'd0, 14'd0, 16'd1}, '{5'd0, 4'd0, 16'd0, 1'b1, 1'b0}},
    '{1'b1, '{DirSub, 5'd1, MonJan, 14'd0, 16'd1}, '{5'd31, MonDec, 16'hFFFF, 1'b0, 1'b1}},
    '{1'b1, '{DirAdd, 5'd31, MonDec, 14'd16383, 16'd1}, '{5'd1, MonJan, 16'd16384, 1'b0, 1'b0}},
    '{1'b1, '{DirAdd, 5'd31, MonApr, 14'd2001, 16'd2}, '{5'd0, MonApr, 16'd2001, 1'b1, 1'b0}},
    '{1'b1, '{DirAdd, 5'd5, MonWrap, 14'd2000, 16'd1}, '{5'd6, MonJan, 16'd2001, 1'b0, 1'b0}},
    '{1'b1, '{DirSub, 5'd1, 4'd15, 14'd100, 16'd2}, '{5'd0, 4'd15, 16'd100, 1'b1, 1'b0}},
    '{1'b1, '{DirSub, 5'd1, MonMar, 14'd2024, 16'd1}, '{5'd29, MonFeb, 16'd2024, 1'b0, 1'b0}},
    '{1'b1, '{DirSub, 5'd1, MonMar, 14'd2023, 16'd1}, '{5'd28, MonFeb, 16'd2023, 1'b0, 1'b0}},
    '{1'b1, '{DirAdd, 5'd28, MonFeb, 14'd2024, 16'd1}, '{5'd29, MonFeb, 16'd2024, 1'b0, 1'b0}},
    '{1'b1, '{DirAdd, 5'd28, MonFeb, 14'd2023, 16'd1}, '{5'd1, MonMar, 16'd2023, 1'b0, 1'b0}},
    '{1'b0, '{DirAdd, 5'd29, MonFeb, 14'd2023, 16'd1}, '0},
    '{1'b0, '{DirAdd, 5'd31, 4'd15, 14'd16383, 16'd40}, '0},
    '{1'b0, '{DirSub, 5'd31, 4'd14, 14'd9999, 16'd100}, '0},
    '{1'b0, '{DirAdd, 5'd30, MonNov, 14'd1999, 16'd400}, '0},
    '{1'b0, '{DirSub, 5'd15, MonAug, 14'd3, 16'd1500}, '0},
    '{1'b0, '{DirAdd, 5'd10, MonOct, 14'd12345, 16'd12000}, '0},
    '{1'b0, '{DirSub, 5'd29, MonFeb, 14'd0, 16'd800}, '0},
    '{1'b0, '{DirAdd, 5'd1, MonJan, 14'd0, 16'hFFFF}, '0},
    '{1'b0, '{DirSub, 5'd1, MonJan, 14'd0, 16'hFFFF}, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_word_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_word_o;

  // Expectation that travels with the word on the request channel
  logic held_typed;
  out_t held_want;

  out_t dates_due [$];
  out_t next_due;
  int   fail_count = 0;
  int   cycle_count = 0;

  calendar_date_add_subtract_days_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic bit leap_year(int y);
    return y[1:0] == 2'b00;
  endfunction

  function automatic bit long_month(logic [MonthW-1:0] m);
    return m inside {MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec};
  endfunction

  function automatic bit short_month(logic [MonthW-1:0] m);
    return m inside {MonApr, MonJun, MonSep, MonNov};
  endfunction

  // Walk the date one day per count, as the block does.
  function automatic out_t shift_date(in_t w);
    logic [DayW:0]     d;
    logic [MonthW-1:0] m;
    int                y;
    int unsigned       n;
    bit                err;
    bit                era;
    out_t              r;
    d   = {1'b0, w.start_day};
    m   = w.start_month;
    y   = int'(w.start_year);
    n   = 32'(w.day_count);
    err = 1'b0;
    era = 1'b0;
    while (n > 0) begin
      if (d == 0 || m == 0) begin
        err = 1'b1;
        break;
      end
      n--;
      if (w.req_type == DirAdd) begin
        d = d + (DayW+1)'(1);
        if (d == DayPast31 && long_month(m)) begin
          d = DayOne;
          m++;
        end
        if (d == DayPast30 && short_month(m)) begin
          d = DayOne;
          m++;
        end
        if (d == DayPast29 && m == MonFeb && leap_year(y)) begin
          d = DayOne;
          m++;
        end
        if (d == DayPast28 && m == MonFeb && !leap_year(y)) begin
          d = DayOne;
          m++;
        end
        if (m == MonWrap) begin
          m = MonJan;
          y++;
        end
        d[DayW] = 1'b0;
      end else begin
        d = d - (DayW+1)'(1);
        if (d == 0) begin
          case (m)
            MonMay, MonJul, MonOct, MonDec: begin
              d = Day30;
              m--;
            end
            MonApr, MonJun, MonAug, MonSep, MonNov, MonJan, MonFeb: begin
              d = Day31;
              m--;
            end
            MonMar: begin
              d = leap_year(y) ? Day29 : Day28;
              m--;
            end
            default: ;  // months 13..15 keep day 0
          endcase
        end
        if (m == 0) begin
          m = MonDec;
          y--;
        end
        if (y < 0) era = 1'b1;
      end
    end
    r.out_day     = d[DayW-1:0];
    r.out_month   = m;
    r.out_year    = y[OyearW-1:0];
    r.input_error = err;
    r.before_era  = era;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(10, 50);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_date(input in_t w, input bit typed, input out_t want, input bit idle_ok);
    int gap;
    gap = idle_ok ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    held_typed <= typed;
    held_want  <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Hold off the request side until every result is back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (dates_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (dates_due.size() == 0) begin
          $error("result word with no date expected");
          fail_count++;
        end else begin
          next_due = dates_due.pop_front();
          check_field("out_day", int'(next_due.out_day), int'(out_word_o.out_day));
          check_field("out_month", int'(next_due.out_month), int'(out_word_o.out_month));
          check_field("out_year", int'($signed(next_due.out_year)),
                      int'($signed(out_word_o.out_year)));
          check_field("input_error", int'(next_due.input_error),
                      int'(out_word_o.input_error));
          check_field("before_era", int'(next_due.before_era), int'(out_word_o.before_era));
        end
      end
      if (in_valid_i && in_ready_o)
        dates_due.push_back(held_typed ? held_want : shift_date(in_word_i));
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == MaxCycles) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : result_sink
    int run;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      out_ready_i <= 1'b0;
      repeat (pick_gap() + 1) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    in_t w;
    in_valid_i = 1'b0;
    in_word_i  = '0;
    held_typed = 1'b0;
    held_want  = '0;
    wait (rst_ni);
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++)
      send_date(DirRows[i].word, DirRows[i].typed, DirRows[i].want, 1'b1);
    drain_results();

    for (int i = 0; i < NumRandom; i++) begin
      w.req_type = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 85) begin
        w.start_day   = DayW'($urandom_range(1, 31));
        w.start_month = MonthW'($urandom_range(1, 12));
      end else begin
        w.start_day   = DayW'($urandom_range(0, 31));
        w.start_month = MonthW'($urandom_range(0, 15));
      end
      // Years near zero let subtraction cross into negative years
      w.start_year = SyearW'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                         : $urandom_range(0, 16383));
      if (i % 25 == 12) w.day_count = CountW'($urandom_range(0, 65535));
      else if ($urandom_range(0, 4) == 0) w.day_count = CountW'($urandom_range(0, 2000));
      else w.day_count = CountW'($urandom_range(0, 60));
      // Back-to-back words for a stretch
      send_date(w, 1'b0, '0, !(i >= 40 && i < 60));
      if (i == 70) drain_results();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
rtl/cdad_pkg.sv
rtl/cdad_datapath.sv
rtl/cdad_ctrl.sv
rtl/calendar_date_add_subtract_days_top.sv
rtl/calendar_date_add_subtract_days_chk.sv
dv/tb_top.sv
